// ===== design/assert_macros.svh =====
// Assertion macros for the swept box collision block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/sbct_pkg.sv =====
// Package for the swept box collision block: widths, register indexes,
// sequencer opcodes and the control store. No dependencies.
package sbct_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int SIZE_W         = 10;
    localparam int CFG_IDX_W      = 4;
    localparam int PC_W           = 5;

    localparam logic [CFG_IDX_W-1:0] REG_MOVER_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVER_Y       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVER_Z       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y        = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Z        = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOVER_SIZE_XY = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOVER_SIZE_Z  = 4'd7;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_DIVM,
        OP_DIVX,
        OP_DIVY,
        OP_DIVZ,
        OP_WAIT,
        OP_SETN,
        OP_SETX,
        OP_SETY,
        OP_SETZ,
        OP_TESTPT,
        OP_STEP,
        OP_TESTDST,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        CND_NONE,
        CND_ALWAYS,
        CND_SHARED,
        CND_NLE1,
        CND_HIT,
        CND_MORE
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    localparam logic [PC_W-1:0] PC_LOAD = 5'd0;
    localparam logic [PC_W-1:0] PC_TEST = 5'd13;
    localparam logic [PC_W-1:0] PC_DEST = 5'd15;
    localparam logic [PC_W-1:0] PC_DONE = 5'd16;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = '{OP_LOAD,    CND_SHARED, PC_DONE};
            5'd1:    w = '{OP_DIVM,    CND_NONE,   PC_LOAD};
            5'd2:    w = '{OP_WAIT,    CND_NONE,   PC_LOAD};
            5'd3:    w = '{OP_SETN,    CND_NLE1,   PC_DEST};
            5'd4:    w = '{OP_DIVX,    CND_NONE,   PC_LOAD};
            5'd5:    w = '{OP_WAIT,    CND_NONE,   PC_LOAD};
            5'd6:    w = '{OP_SETX,    CND_NONE,   PC_LOAD};
            5'd7:    w = '{OP_DIVY,    CND_NONE,   PC_LOAD};
            5'd8:    w = '{OP_WAIT,    CND_NONE,   PC_LOAD};
            5'd9:    w = '{OP_SETY,    CND_NONE,   PC_LOAD};
            5'd10:   w = '{OP_DIVZ,    CND_NONE,   PC_LOAD};
            5'd11:   w = '{OP_WAIT,    CND_NONE,   PC_LOAD};
            5'd12:   w = '{OP_SETZ,    CND_NONE,   PC_LOAD};
            5'd13:   w = '{OP_TESTPT,  CND_HIT,    PC_DONE};
            5'd14:   w = '{OP_STEP,    CND_MORE,   PC_TEST};
            5'd15:   w = '{OP_TESTDST, CND_NONE,   PC_LOAD};
            5'd16:   w = '{OP_DONE,    CND_ALWAYS, PC_LOAD};
            default: w = '{OP_DONE,    CND_ALWAYS, PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ===== design/sbct_item_if.sv =====
// Input channel: one other object per request.
// Depends on sbct_pkg for default widths.
interface sbct_item_if #(
    parameter int COORD_BITS = sbct_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         other_x;
    logic [COORD_BITS-1:0]         other_y;
    logic [COORD_BITS-1:0]         other_z;
    logic [sbct_pkg::SIZE_W-1:0]   other_size_xy;
    logic [sbct_pkg::SIZE_W-1:0]   other_size_z;
    logic                          shares_parent;

    modport source (
        output valid, other_x, other_y, other_z, other_size_xy, other_size_z,
               shares_parent,
        input  ready
    );
    modport sink (
        input  valid, other_x, other_y, other_z, other_size_xy, other_size_z,
               shares_parent,
        output ready
    );
endinterface

// ===== design/sbct_result_if.sv =====
// Result channel: one collide bit per request.
// No dependencies.
interface sbct_result_if;
    logic valid;
    logic ready;
    logic collide;

    modport source (output valid, collide, input ready);
    modport sink   (input valid, collide, output ready);
endinterface

// ===== design/sbct_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on sbct_pkg for the default width.
module sbct_div #(
    parameter int W = sbct_pkg::COORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         busy,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);
    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] CNT_INIT = CW'(W);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, rem_reg, den_reg;
    logic [W:0]    trial, diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_INIT;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;
endmodule

// ===== design/swept_box_collision_test.sv =====
// Swept box collision test: microcoded sequencer over a shared divider.
// Depends on sbct_pkg, sbct_item_if, sbct_result_if, sbct_div, assert_macros.svh.
//
//   channel   dir  handshake        payload
//   item      in   valid/ready      other_x/y/z, other_size_xy/z, shares_parent
//   result    out  valid/ready      collide
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// One request at a time. A shared parent goes straight to the result, reported
// as no collision. Fewer than two samples: only the destination is tested.
// Otherwise the serial divider (DW = max(COORD_BITS, 10)) runs four divides,
// the sample count n and the x/y/z steps, and the two-step sample loop tests
// samples 1 to n-1, then the destination. A hit ends the loop early.
// Reset clears control and configuration registers at once; no clearing pass.
// A waiting result holds the sequencer in its last step until the result register
// is free or being drained; the next request does not wait for the result's read.
`include "assert_macros.svh"
module swept_box_collision_test #(
    parameter int COORD_BITS = sbct_pkg::COORD_BITS_DEF,
    localparam int DW = (COORD_BITS > sbct_pkg::SIZE_W) ? COORD_BITS : sbct_pkg::SIZE_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sbct_item_if.sink                       item,
    sbct_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [sbct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [DW-1:0]                   cfg_data
);
    localparam int C  = COORD_BITS;
    localparam int SW = sbct_pkg::SIZE_W;
    localparam int PW = DW + 2;

    // configuration
    logic [C-1:0]  start_reg [3];
    logic [C-1:0]  dest_reg  [3];
    logic [SW-1:0] msxy_reg, msz_reg;

    // latched request
    logic [C-1:0]  other_reg [3];
    logic [SW-1:0] osxy_reg, osz_reg;

    // sample walk
    logic [C-1:0]  n_reg, i_reg;
    logic [C-1:0]  q_reg [3];
    logic [C-1:0]  r_reg [3];
    logic [C-1:0]  q0_reg [3];
    logic [C-1:0]  r0_reg [3];
    logic [C-1:0]  q_next [3];
    logic [C-1:0]  r_next [3];

    // control
    logic [sbct_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                      hit_reg, hit_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      collide_reg;

    sbct_pkg::uword_t uw;
    logic             stall, taken;
    logic             in_fire, out_fire;

    // path deltas
    logic signed [C:0] dlt [3];
    logic signed [C:0] ndlt [3];
    logic [C-1:0]      mag [3];
    logic              neg [3];
    logic signed [C:0] m_max;
    logic [C-1:0]      m_pos;
    logic [SW:0]       sxy_sum, sz_sum;
    logic [SW-1:0]     lim;

    // divider
    logic          div_start, div_busy;
    logic [DW-1:0] div_num, div_den, div_quo, div_rem;

    // overlap unit
    logic [C-1:0]          pt [3];
    logic signed [PW-1:0]  ax, ay, ez;
    logic [PW-1:0]         cxy, cz;
    logic                  overlap;

    function automatic logic [PW-1:0] absv(input logic signed [PW-1:0] v);
        return (v < 0) ? PW'(-v) : PW'(v);
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dlt[k]  = $signed({1'b0, dest_reg[k]}) - $signed({1'b0, start_reg[k]});
            ndlt[k] = -dlt[k];
            neg[k]  = dlt[k][C];
            mag[k]  = neg[k] ? ndlt[k][C-1:0] : dlt[k][C-1:0];
        end
        m_max = dlt[0];
        if (dlt[1] > m_max)
        begin
            m_max = dlt[1];
        end
        if (dlt[2] > m_max)
        begin
            m_max = dlt[2];
        end
        m_pos = (m_max > 0) ? m_max[C-1:0] : '0;
    end

    assign sxy_sum = {1'b0, osxy_reg} + {1'b0, msxy_reg};
    assign sz_sum  = {1'b0, osz_reg} + {1'b0, msz_reg};
    assign lim     = SW'(sxy_sum[SW:2]) + SW'(1);

    assign uw       = sbct_pkg::ucode(pc_reg);
    assign in_fire  = item.valid && item.ready;
    assign out_fire = result.valid && result.ready;

    // divider operand select
    always_comb
    begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = DW'(n_reg);
        case (uw.op)
            sbct_pkg::OP_DIVM:
            begin
                div_num = DW'(m_pos);
                div_den = DW'(lim);
            end
            sbct_pkg::OP_DIVX: div_num = DW'(mag[0]);
            sbct_pkg::OP_DIVY: div_num = DW'(mag[1]);
            sbct_pkg::OP_DIVZ: div_num = DW'(mag[2]);
            default:           div_start = 1'b0;
        endcase
    end

    sbct_div #(.W(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // next sample: q += q0, r += r0 with carry into q
    always_comb
    begin
        logic [C:0] rsum;
        logic       wrap;
        for (int k = 0; k < 3; k++)
        begin
            rsum      = {1'b0, r_reg[k]} + {1'b0, r0_reg[k]};
            wrap      = rsum >= {1'b0, n_reg};
            q_next[k] = q_reg[k] + q0_reg[k] + C'(wrap);
            r_next[k] = wrap ? C'(rsum - {1'b0, n_reg}) : rsum[C-1:0];
        end
    end

    // overlap test at the sample point or the destination
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (uw.op == sbct_pkg::OP_TESTDST)
            begin
                pt[k] = dest_reg[k];
            end
            else
            begin
                pt[k] = neg[k] ? start_reg[k] - q_reg[k] : start_reg[k] + q_reg[k];
            end
        end
        ax  = $signed(PW'(pt[0])) - $signed(PW'(other_reg[0]));
        ay  = $signed(PW'(pt[1])) - $signed(PW'(other_reg[1]));
        ez  = $signed(PW'(pt[2])) - $signed(PW'(other_reg[2]))
            - $signed(PW'(osz_reg >> 1)) + $signed(PW'(msz_reg >> 1));
        cxy = PW'(sxy_sum[SW:1]);
        cz  = PW'(sz_sum[SW:1]);
        overlap = (absv(ax) < cxy) && (absv(ay) < cxy) && (absv(ez) < cz);
    end

    assign item.ready = (uw.op == sbct_pkg::OP_LOAD);

    // sequencer
    always_comb
    begin
        case (uw.op)
            sbct_pkg::OP_LOAD: stall = !item.valid;
            sbct_pkg::OP_WAIT: stall = div_busy;
            sbct_pkg::OP_DONE: stall = out_valid_reg && !result.ready;
            default:           stall = 1'b0;
        endcase
        case (uw.cond)
            sbct_pkg::CND_NONE:   taken = 1'b0;
            sbct_pkg::CND_ALWAYS: taken = 1'b1;
            sbct_pkg::CND_SHARED: taken = item.shares_parent;
            sbct_pkg::CND_NLE1:   taken = div_quo < DW'(2);
            sbct_pkg::CND_HIT:    taken = overlap;
            sbct_pkg::CND_MORE:   taken = ({1'b0, i_reg} + 1'b1) != {1'b0, n_reg};
            default:              taken = 1'b0;
        endcase
        if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end

        hit_next = hit_reg;
        case (uw.op)
            sbct_pkg::OP_LOAD:    hit_next = in_fire ? 1'b0 : hit_reg;
            sbct_pkg::OP_TESTPT:  hit_next = overlap;
            sbct_pkg::OP_TESTDST: hit_next = overlap;
            default:              hit_next = hit_reg;
        endcase

        if (uw.op == sbct_pkg::OP_DONE && !stall)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= sbct_pkg::PC_LOAD;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                start_reg[k] <= '0;
                dest_reg[k]  <= '0;
            end
            msxy_reg <= '0;
            msz_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbct_pkg::REG_MOVER_X:       start_reg[0] <= cfg_data[C-1:0];
                sbct_pkg::REG_MOVER_Y:       start_reg[1] <= cfg_data[C-1:0];
                sbct_pkg::REG_MOVER_Z:       start_reg[2] <= cfg_data[C-1:0];
                sbct_pkg::REG_DEST_X:        dest_reg[0]  <= cfg_data[C-1:0];
                sbct_pkg::REG_DEST_Y:        dest_reg[1]  <= cfg_data[C-1:0];
                sbct_pkg::REG_DEST_Z:        dest_reg[2]  <= cfg_data[C-1:0];
                sbct_pkg::REG_MOVER_SIZE_XY: msxy_reg     <= cfg_data[SW-1:0];
                sbct_pkg::REG_MOVER_SIZE_Z:  msz_reg      <= cfg_data[SW-1:0];
                default:                     msz_reg      <= msz_reg;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (uw.op)
            sbct_pkg::OP_LOAD:
            begin
                if (in_fire)
                begin
                    other_reg[0] <= item.other_x;
                    other_reg[1] <= item.other_y;
                    other_reg[2] <= item.other_z;
                    osxy_reg     <= item.other_size_xy;
                    osz_reg      <= item.other_size_z;
                end
            end
            sbct_pkg::OP_SETN:
            begin
                n_reg <= div_quo[C-1:0];
                i_reg <= C'(1);
            end
            sbct_pkg::OP_SETX:
            begin
                q_reg[0]  <= div_quo[C-1:0];
                r_reg[0]  <= div_rem[C-1:0];
                q0_reg[0] <= div_quo[C-1:0];
                r0_reg[0] <= div_rem[C-1:0];
            end
            sbct_pkg::OP_SETY:
            begin
                q_reg[1]  <= div_quo[C-1:0];
                r_reg[1]  <= div_rem[C-1:0];
                q0_reg[1] <= div_quo[C-1:0];
                r0_reg[1] <= div_rem[C-1:0];
            end
            sbct_pkg::OP_SETZ:
            begin
                q_reg[2]  <= div_quo[C-1:0];
                r_reg[2]  <= div_rem[C-1:0];
                q0_reg[2] <= div_quo[C-1:0];
                r0_reg[2] <= div_rem[C-1:0];
            end
            sbct_pkg::OP_STEP:
            begin
                i_reg <= i_reg + C'(1);
                for (int k = 0; k < 3; k++)
                begin
                    q_reg[k] <= q_next[k];
                    r_reg[k] <= r_next[k];
                end
            end
            sbct_pkg::OP_DONE:
            begin
                if (!stall)
                begin
                    collide_reg <= hit_reg;
                end
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

    assign result.valid   = out_valid_reg;
    assign result.collide = collide_reg;

    `ASSERT_IMPLIES(a_load_div_idle, uw.op == sbct_pkg::OP_LOAD, !div_busy, "divider busy at load")
    `ASSERT_IMPLIES(a_sample_in_range, uw.op == sbct_pkg::OP_TESTPT, (i_reg != '0) && (i_reg < n_reg), "sample index out of range")
    `ASSERT_NEXT(a_shared_no_hit, in_fire && item.shares_parent, (pc_reg == sbct_pkg::PC_DONE) && !hit_reg, "shared parent not short-cut")
endmodule
